FILE: hw/rtl/integer_to_text_formatter_defines.svh
// ----------------------------------------------------------------------------
// Integer to text formatter: assertion macros
// Shared checks use the enclosing module's clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// checked only out of reset
`define ITF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ITF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/itf_pkg.sv
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Types, codes and character helpers shared by the formatter files.
// ----------------------------------------------------------------------------
package itf_pkg;

  // conversion codes
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_OCT  = 2'd2;
  localparam logic [1:0] OP_HEX  = 2'd3;

  // operand size codes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_HALF  = 2'd1;
  localparam logic [1:0] SZ_WORD  = 2'd2;
  localparam logic [1:0] SZ_DWORD = 2'd3;

  localparam int VAL_W = 64;
  localparam int ND    = 22;          // digit slots: 22 octal digits cover 64 bits
  localparam int DIG_W = ND * 4;
  localparam int NDIG_W = 5;          // holds 0..ND
  localparam int CNT_W = 8;           // lengths, padding and positions
  localparam int ITER_W = 7;          // double-dabble iterations, up to 64

  localparam logic [0:15][7:0] DIGITS_LC = "0123456789abcdef";
  localparam logic [0:15][7:0] DIGITS_UC = "0123456789ABCDEF";

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LC  = 8'h78;
  localparam logic [7:0] CH_X_UC  = 8'h58;

  // command to the digit unit
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
  } itf_dcmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    digit_char = upper ? DIGITS_UC[nib] : DIGITS_LC[nib];
  endfunction

endpackage

FILE: hw/rtl/itf_channels.sv
// ----------------------------------------------------------------------------
// Integer to text formatter channels
// Valid/ready interfaces for the operand word and the character word.
// ----------------------------------------------------------------------------
interface itf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  opcode;
  logic [1:0]  size_code;
  logic [5:0]  field_width;
  logic        precision_given;
  logic [5:0]  precision;
  logic        left_justify;
  logic        force_plus;
  logic        blank_sign;
  logic        alternate;
  logic        zero_pad;
  logic        upper_case;

  modport source (
    output valid, value, opcode, size_code, field_width, precision_given, precision,
           left_justify, force_plus, blank_sign, alternate, zero_pad, upper_case,
    input  ready
  );
  modport sink (
    input  valid, value, opcode, size_code, field_width, precision_given, precision,
           left_justify, force_plus, blank_sign, alternate, zero_pad, upper_case,
    output ready
  );
endinterface

interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink   (input valid, character, last_char, output ready);
endinterface

FILE: hw/rtl/itf_digit_unit.sv
// ----------------------------------------------------------------------------
// Digit unit
// Digit shift register with one double-dabble step per cycle for decimal,
// a direct load for octal and hex, and a left shift that drops the top digit.
// ----------------------------------------------------------------------------
module itf_digit_unit (
  input  logic                      clk,
  input  itf_pkg::itf_dcmd_t        cmd,
  input  logic [itf_pkg::DIG_W-1:0] load_dig,
  input  logic [itf_pkg::VAL_W-1:0] load_bin,
  output logic [3:0]                top_nib
);
  import itf_pkg::*;

  logic [DIG_W-1:0] dig_r, dig_nxt, adj;
  logic [VAL_W-1:0] bin_r, bin_nxt;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3 : dig_r[4*i +: 4];
    end
  end

  always_comb begin
    dig_nxt = dig_r;
    bin_nxt = bin_r;
    if (cmd.load) begin
      dig_nxt = load_dig;
      bin_nxt = load_bin;
    end else if (cmd.dabble) begin
      dig_nxt = {adj[DIG_W-2:0], bin_r[VAL_W-1]};
      bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
    end else if (cmd.shift) begin
      dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    bin_r <= bin_nxt;
  end

  assign top_nib = dig_r[DIG_W-1 -: 4];

endmodule

FILE: hw/rtl/integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// Integer to text formatter
// printf-style d/u/o/x conversion of a 1/2/4/8 byte operand into ASCII text,
// one character per output word, last character flagged.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    value, opcode, size_code, width/precision, flags
//   out_ch   out  valid/ready    character, last_char
//
// Decimal: one double-dabble step per operand bit (8/16/32/64), one bit per
// cycle; octal/hex skip it. Leading zero digits are then stripped (up to 21),
// lengths set in S_PLAN/S_PAD; one char per unstalled cycle, at most MAX_FIELD.
// in_ch.ready is high only when idle; out_ch stalls hold the sequencer in emit.
// rst_n is synchronous, active low, and clears the sequencer and output valid.
// ----------------------------------------------------------------------------
`include "integer_to_text_formatter_defines.svh"

module integer_to_text_formatter #(
  parameter int MAX_FIELD = 60
) (
  input  logic  clk,
  input  logic  rst_n,
  itf_in_if.sink    in_ch,
  itf_out_if.source out_ch
);
  import itf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CONV = 6'b000010,
    S_SCAN = 6'b000100,
    S_PLAN = 6'b001000,
    S_PAD  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  localparam logic [CNT_W-1:0] MAXF      = CNT_W'(MAX_FIELD);
  localparam logic [CNT_W-1:0] MAXF_LAST = CNT_W'(MAX_FIELD - 1);
  localparam logic [CNT_W-1:0] MAXP      = CNT_W'(MAX_FIELD - 2);

  state_t state_r, state_nxt;

  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [NDIG_W-1:0] ndig_r, ndig_nxt;
  logic              mag_zero_r, mag_zero_nxt;
  logic              prec_given_r, prec_given_nxt;
  logic [5:0]        prec_r, prec_nxt;
  logic [CNT_W-1:0]  width_r, width_nxt;
  logic              left_r, left_nxt;
  logic              zfill_r, zfill_nxt;
  logic              upper_r, upper_nxt;
  logic              oct_alt_r, oct_alt_nxt;
  logic [1:0]        pre_cnt_r, pre_cnt_nxt;
  logic [7:0]        pre_char_r, pre_char_nxt;
  logic [CNT_W-1:0]  zeros_r, zeros_nxt;
  logic [CNT_W-1:0]  spaces_r, spaces_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  // operand decode
  logic              in_fire;
  logic [VAL_W-1:0]  mask, mag, mag_abs, bin_al;
  logic [ITER_W-1:0] nbits;
  logic              msb, neg, is_dec;
  logic [7:0]        sign_ch;
  logic [DIG_W-1:0]  dig_ld;
  logic [VAL_W+1:0]  mag3;
  logic [CNT_W-1:0]  fw_ext, md_ext;

  itf_dcmd_t dcmd;
  logic [3:0] top_nib;

  // plan arithmetic
  logic [CNT_W-1:0] prec_ext, ndig_ext, z_plan;

  // emit
  logic       slot_free, emit_fire, emit_last;
  logic [7:0] emit_ch;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    case (in_ch.size_code)
      SZ_BYTE: begin
        mask = 64'h0000_0000_0000_00ff; nbits = ITER_W'(8);
        msb = in_ch.value[7];
      end
      SZ_HALF: begin
        mask = 64'h0000_0000_0000_ffff; nbits = ITER_W'(16);
        msb = in_ch.value[15];
      end
      SZ_WORD: begin
        mask = 64'h0000_0000_ffff_ffff; nbits = ITER_W'(32);
        msb = in_ch.value[31];
      end
      default: begin
        mask = 64'hffff_ffff_ffff_ffff; nbits = ITER_W'(64);
        msb = in_ch.value[63];
      end
    endcase
    mag     = in_ch.value & mask;
    neg     = (in_ch.opcode == OP_SDEC) && msb;
    mag_abs = neg ? ((~mag + 64'd1) & mask) : mag;
    // left-align the operand so the dabble only runs over its bits
    case (in_ch.size_code)
      SZ_BYTE: bin_al = mag_abs << 56;
      SZ_HALF: bin_al = mag_abs << 48;
      SZ_WORD: bin_al = mag_abs << 32;
      default: bin_al = mag_abs;
    endcase
    is_dec = (in_ch.opcode == OP_SDEC) || (in_ch.opcode == OP_UDEC);
    if (neg)                    sign_ch = CH_MINUS;
    else if (in_ch.force_plus)  sign_ch = CH_PLUS;
    else                        sign_ch = CH_SPACE;

    mag3   = {2'b00, mag_abs};
    dig_ld = '0;
    if (in_ch.opcode == OP_HEX) begin
      for (int i = 0; i < 16; i++) dig_ld[4*i +: 4] = mag_abs[4*i +: 4];
    end else if (in_ch.opcode == OP_OCT) begin
      for (int i = 0; i < ND; i++) dig_ld[4*i +: 4] = {1'b0, mag3[3*i +: 3]};
    end

    fw_ext = CNT_W'(in_ch.field_width);
    md_ext = CNT_W'(in_ch.precision);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ndig_nxt       = ndig_r;
    mag_zero_nxt   = mag_zero_r;
    prec_given_nxt = prec_given_r;
    prec_nxt       = prec_r;
    width_nxt      = width_r;
    left_nxt       = left_r;
    zfill_nxt      = zfill_r;
    upper_nxt      = upper_r;
    oct_alt_nxt    = oct_alt_r;
    pre_cnt_nxt    = pre_cnt_r;
    pre_char_nxt   = pre_char_r;
    zeros_nxt      = zeros_r;
    spaces_nxt     = spaces_r;
    total_nxt      = total_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    dcmd           = '0;
    emit_fire      = 1'b0;

    prec_ext = CNT_W'(prec_r);
    ndig_ext = CNT_W'(ndig_r);
    z_plan   = (prec_given_r && (prec_ext > ndig_ext)) ? prec_ext - ndig_ext : '0;
    // octal alternate form: a leading zero unless the text starts with one
    if (oct_alt_r && (z_plan == '0) && (!mag_zero_r || prec_given_r))
      z_plan = CNT_W'(1);

    slot_free = !out_valid_r || out_ch.ready;
    emit_last = (rem_r == CNT_W'(1)) || (pos_r == MAXF_LAST);
    if (!left_r && (spaces_r != '0))  emit_ch = CH_SPACE;
    else if (pre_cnt_r == 2'd2)        emit_ch = CH_ZERO;
    else if (pre_cnt_r == 2'd1)        emit_ch = pre_char_r;
    else if (zeros_r != '0)            emit_ch = CH_ZERO;
    else if (ndig_r != '0)             emit_ch = digit_char(top_nib, upper_r);
    else                               emit_ch = CH_SPACE;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dcmd.load      = 1'b1;
          cnt_nxt        = nbits;
          ndig_nxt       = NDIG_W'(ND);
          mag_zero_nxt   = (mag == '0);
          prec_given_nxt = in_ch.precision_given;
          prec_nxt       = (md_ext > MAXP) ? MAXP[5:0] : in_ch.precision;
          width_nxt      = (fw_ext > MAXF) ? MAXF : fw_ext;
          left_nxt       = in_ch.left_justify;
          zfill_nxt      = in_ch.zero_pad && !in_ch.left_justify && !in_ch.precision_given;
          upper_nxt      = in_ch.upper_case;
          oct_alt_nxt    = (in_ch.opcode == OP_OCT) && in_ch.alternate;
          if ((in_ch.opcode == OP_SDEC) &&
              (neg || in_ch.force_plus || in_ch.blank_sign)) begin
            pre_cnt_nxt  = 2'd1;
            pre_char_nxt = sign_ch;
          end else if ((in_ch.opcode == OP_HEX) && in_ch.alternate && (mag != '0)) begin
            pre_cnt_nxt  = 2'd2;
            pre_char_nxt = in_ch.upper_case ? CH_X_UC : CH_X_LC;
          end else begin
            pre_cnt_nxt  = 2'd0;
            pre_char_nxt = sign_ch;
          end
          state_nxt = is_dec ? S_CONV : S_SCAN;
        end
      end
      S_CONV: begin
        dcmd.dabble = 1'b1;
        cnt_nxt     = cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if ((ndig_r > NDIG_W'(1)) && (top_nib == 4'd0)) begin
          dcmd.shift = 1'b1;
          ndig_nxt   = ndig_r - NDIG_W'(1);
        end else begin
          if (prec_given_r && mag_zero_r) ndig_nxt = '0;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        zeros_nxt = z_plan;
        total_nxt = CNT_W'(pre_cnt_r) + z_plan + ndig_ext;
        state_nxt = S_PAD;
      end
      S_PAD: begin
        pos_nxt = '0;
        if (width_r > total_r) begin
          rem_nxt = width_r;
          if (zfill_r) begin
            zeros_nxt  = zeros_r + (width_r - total_r);
            spaces_nxt = '0;
          end else begin
            spaces_nxt = width_r - total_r;
          end
        end else begin
          rem_nxt    = total_r;
          spaces_nxt = '0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;           // empty text: nothing to send
        end else if (slot_free) begin
          emit_fire = 1'b1;
          rem_nxt   = rem_r - CNT_W'(1);
          pos_nxt   = pos_r + CNT_W'(1);
          if (!left_r && (spaces_r != '0))  spaces_nxt  = spaces_r - CNT_W'(1);
          else if (pre_cnt_r != 2'd0)        pre_cnt_nxt = pre_cnt_r - 2'd1;
          else if (zeros_r != '0)            zeros_nxt   = zeros_r - CNT_W'(1);
          else if (ndig_r != '0) begin
            ndig_nxt   = ndig_r - NDIG_W'(1);
            dcmd.shift = 1'b1;
          end else                           spaces_nxt  = spaces_r - CNT_W'(1);
          if (emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_ch;
      out_last_nxt  = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  itf_digit_unit u_digits (
    .clk      (clk),
    .cmd      (dcmd),
    .load_dig (dig_ld),
    .load_bin (bin_al),
    .top_nib  (top_nib)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    ndig_r       <= ndig_nxt;
    mag_zero_r   <= mag_zero_nxt;
    prec_given_r <= prec_given_nxt;
    prec_r       <= prec_nxt;
    width_r      <= width_nxt;
    left_r       <= left_nxt;
    zfill_r      <= zfill_nxt;
    upper_r      <= upper_nxt;
    oct_alt_r    <= oct_alt_nxt;
    pre_cnt_r    <= pre_cnt_nxt;
    pre_char_r   <= pre_char_nxt;
    zeros_r      <= zeros_nxt;
    spaces_r     <= spaces_nxt;
    total_r      <= total_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last_char = out_last_r;

  // an accepted word starts either the dabble or the digit scan
  `ITF_ASSERT(a_start, in_fire |=> (state_r == S_CONV) || (state_r == S_SCAN), "bad start")
  // the dabble counter never wraps
  `ITF_ASSERT(a_cnt, (state_r == S_CONV) |-> (cnt_r != '0), "dabble count ran out")
  // output is truncated at the field limit
  `ITF_ASSERT(a_pos, (state_r == S_EMIT) |-> (pos_r < MAXF), "position past field limit")
  // the last character closes the conversion
  `ITF_ASSERT(a_done, (emit_fire && emit_last) |=> (state_r == S_IDLE), "no return after last")

endmodule
